// ===== src/ufp_pkg.sv =====
package ufp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned HDR_W  = 16;
   localparam int unsigned POS_W  = 9;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned STAT_W = 3;
   localparam int unsigned IDX_W  = 3;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_HEADER_WORD     = 3'd0;
   localparam logic [IDX_W-1:0] REG_END_BYTE        = 3'd1;
   localparam logic [IDX_W-1:0] REG_CMD_SYNC        = 3'd2;
   localparam logic [IDX_W-1:0] REG_CMD_ASK_UPDATE  = 3'd3;
   localparam logic [IDX_W-1:0] REG_CMD_UPDATE_DATA = 3'd4;
   localparam logic [IDX_W-1:0] REG_CMD_VERIFY      = 3'd5;
   localparam logic [IDX_W-1:0] REG_CMD_UPDATE_END  = 3'd6;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ABORT    = 2'd2;

   // update status codes
   localparam logic [STAT_W-1:0] ST_WAIT  = 3'd0;
   localparam logic [STAT_W-1:0] ST_START = 3'd1;
   localparam logic [STAT_W-1:0] ST_PROG  = 3'd2;
   localparam logic [STAT_W-1:0] ST_CHECK = 3'd3;
   localparam logic [STAT_W-1:0] ST_END   = 3'd4;
   localparam logic [STAT_W-1:0] ST_NONE  = 3'd5;

   // frame positions before the payload
   localparam logic [POS_W-1:0] POS_HDR_LO = 9'd0;
   localparam logic [POS_W-1:0] POS_HDR_HI = 9'd1;
   localparam logic [POS_W-1:0] POS_CMD    = 9'd2;
   localparam logic [POS_W-1:0] POS_LEN    = 9'd3;
   localparam logic [POS_W-1:0] POS_PAY    = 9'd4;

   typedef struct packed {
      logic [HDR_W-1:0]  header_word;
      logic [BYTE_W-1:0] end_byte;
      logic [BYTE_W-1:0] cmd_sync;
      logic [BYTE_W-1:0] cmd_ask_update;
      logic [BYTE_W-1:0] cmd_update_data;
      logic [BYTE_W-1:0] cmd_verify;
      logic [BYTE_W-1:0] cmd_update_end;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] sequence_res;
      logic [STAT_W-1:0] status_code;
   } result_type;

endpackage

// ===== src/update_frame_parser.sv =====
// Deframes bootloader command frames (header low, header high, command, length,
// payload, sequence, end) from a stream of received bytes, one byte per cycle
// while req_stall is low. A byte is registered on transfer and parsed from
// that register once the output buffer has room; each payload byte gives a
// result, a good end byte gives a frame-complete result carrying the mapped
// update status, and an out-of-place byte after the first header byte gives
// an abort. Results are registered in the output buffer. The result side has a
// two-entry output buffer, so one byte per cycle is sustained as long as
// results are taken; req_stall rises only when that buffer is full.
// Configuration registers may be written only while no frame byte is in flight.
module update_frame_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ufp_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ufp_pkg::KIND_W-1:0]  rsp_kind,
   output logic [ufp_pkg::BYTE_W-1:0]  rsp_data_byte,
   output logic [ufp_pkg::BYTE_W-1:0]  rsp_payload_index,
   output logic [ufp_pkg::BYTE_W-1:0]  rsp_command,
   output logic [ufp_pkg::BYTE_W-1:0]  rsp_length,
   output logic [ufp_pkg::BYTE_W-1:0]  rsp_sequence_res,
   output logic [ufp_pkg::STAT_W-1:0]  rsp_status_code,
   input  logic                        csr_wr_en,
   input  logic [ufp_pkg::IDX_W-1:0]   csr_index,
   input  logic [ufp_pkg::HDR_W-1:0]   csr_wdata
);

   ufp_pkg::cfg_type           cfg;
   ufp_pkg::result_type        res;
   ufp_pkg::result_type        rsp_res;
   logic                       res_valid;
   logic                       buf_full;
   logic                       step;
   logic                       in_vld_ff, in_vld_in;
   logic [ufp_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;

   assign step      = in_vld_ff && !buf_full;
   assign req_stall = in_vld_ff && buf_full;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (step) begin
         in_vld_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_byte_ff <= in_byte_in;
   end

   ufp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ufp_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   ufp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_res  (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_kind          = rsp_res.kind;
   assign rsp_data_byte     = rsp_res.data_byte;
   assign rsp_payload_index = rsp_res.payload_index;
   assign rsp_command       = rsp_res.command;
   assign rsp_length        = rsp_res.length;
   assign rsp_sequence_res  = rsp_res.sequence_res;
   assign rsp_status_code   = rsp_res.status_code;

endmodule

// ===== src/ufp_csr.sv =====
module ufp_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [ufp_pkg::IDX_W-1:0]  csr_index,
   input  logic [ufp_pkg::HDR_W-1:0]  csr_wdata,
   output ufp_pkg::cfg_type           cfg
);

   ufp_pkg::cfg_type cfg_ff;
   ufp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ufp_pkg::REG_HEADER_WORD:     cfg_in.header_word     = csr_wdata;
            ufp_pkg::REG_END_BYTE:        cfg_in.end_byte        = csr_wdata[7:0];
            ufp_pkg::REG_CMD_SYNC:        cfg_in.cmd_sync        = csr_wdata[7:0];
            ufp_pkg::REG_CMD_ASK_UPDATE:  cfg_in.cmd_ask_update  = csr_wdata[7:0];
            ufp_pkg::REG_CMD_UPDATE_DATA: cfg_in.cmd_update_data = csr_wdata[7:0];
            ufp_pkg::REG_CMD_VERIFY:      cfg_in.cmd_verify      = csr_wdata[7:0];
            ufp_pkg::REG_CMD_UPDATE_END:  cfg_in.cmd_update_end  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/ufp_deframer.sv =====
module ufp_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [ufp_pkg::BYTE_W-1:0]  rx_byte,
   input  ufp_pkg::cfg_type            cfg,
   output logic                        res_valid,
   output ufp_pkg::result_type         res
);

   logic [ufp_pkg::POS_W-1:0]  position_ff, position_in;
   logic [ufp_pkg::BYTE_W-1:0] command_ff, command_in;
   logic [ufp_pkg::BYTE_W-1:0] length_ff, length_in;
   logic [ufp_pkg::BYTE_W-1:0] sequence_ff, sequence_in;
   logic [ufp_pkg::STAT_W-1:0] status_ff, status_in;

   logic [ufp_pkg::POS_W-1:0]  pay_end;
   logic [ufp_pkg::POS_W-1:0]  pay_idx;
   logic [ufp_pkg::STAT_W-1:0] status_map;

   assign pay_end = ufp_pkg::POS_PAY + {1'b0, length_ff};
   assign pay_idx = position_ff - ufp_pkg::POS_PAY;

   // first match wins
   always_comb begin
      if (command_ff == cfg.cmd_sync) begin
         status_map = ufp_pkg::ST_WAIT;
      end else if (command_ff == cfg.cmd_ask_update) begin
         status_map = ufp_pkg::ST_START;
      end else if (command_ff == cfg.cmd_update_data) begin
         status_map = ufp_pkg::ST_PROG;
      end else if (command_ff == cfg.cmd_verify) begin
         status_map = ufp_pkg::ST_CHECK;
      end else if (command_ff == cfg.cmd_update_end) begin
         status_map = ufp_pkg::ST_END;
      end else begin
         status_map = status_ff;
      end
   end

   always_comb begin
      position_in = position_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      sequence_in = sequence_ff;
      status_in   = status_ff;
      res_valid   = 1'b0;
      res         = '0;
      res.kind    = ufp_pkg::KIND_ABORT;

      if (position_ff == ufp_pkg::POS_HDR_LO) begin
         // idle noise is dropped silently
         if (rx_byte == cfg.header_word[7:0]) begin
            position_in = ufp_pkg::POS_HDR_HI;
         end
      end else if (position_ff == ufp_pkg::POS_HDR_HI) begin
         if (rx_byte == cfg.header_word[15:8]) begin
            position_in = ufp_pkg::POS_CMD;
         end else begin
            position_in = ufp_pkg::POS_HDR_LO;
            res_valid   = 1'b1;
         end
      end else if (position_ff == ufp_pkg::POS_CMD) begin
         command_in  = rx_byte;
         position_in = ufp_pkg::POS_LEN;
      end else if (position_ff == ufp_pkg::POS_LEN) begin
         length_in   = rx_byte;
         position_in = ufp_pkg::POS_PAY;
      end else if (position_ff < pay_end) begin
         position_in       = position_ff + 9'd1;
         res_valid         = 1'b1;
         res.kind          = ufp_pkg::KIND_PAYLOAD;
         res.data_byte     = rx_byte;
         res.payload_index = pay_idx[7:0];
      end else if (position_ff == pay_end) begin
         sequence_in = rx_byte;
         position_in = position_ff + 9'd1;
      end else if (position_ff == pay_end + 9'd1 && rx_byte == cfg.end_byte) begin
         status_in        = status_map;
         position_in      = ufp_pkg::POS_HDR_LO;
         res_valid        = 1'b1;
         res.kind         = ufp_pkg::KIND_COMPLETE;
         res.command      = command_ff;
         res.length       = length_ff;
         res.sequence_res = sequence_ff;
      end else begin
         position_in = ufp_pkg::POS_HDR_LO;
         res_valid   = 1'b1;
      end

      res.status_code = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= ufp_pkg::POS_HDR_LO;
         command_ff  <= '0;
         length_ff   <= '0;
         sequence_ff <= '0;
         status_ff   <= ufp_pkg::ST_NONE;
      end else if (step) begin
         position_ff <= position_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         sequence_ff <= sequence_in;
         status_ff   <= status_in;
      end
   end

endmodule

// ===== src/ufp_rsp_buf.sv =====
module ufp_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ufp_pkg::result_type  push_res,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ufp_pkg::result_type  rsp_res
);

   logic                v0_ff, v0_in, v1_ff, v1_in;
   ufp_pkg::result_type e0_ff, e0_in, e1_ff, e1_in;
   logic                pop;

   assign pop = v0_ff && !rsp_stall;

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      // advance the skid entry on a transfer
      if (pop) begin
         e0_in = e1_ff;
         v0_in = v1_ff;
         v1_in = 1'b0;
      end
      if (push) begin
         if (!v0_in) begin
            e0_in = push_res;
            v0_in = 1'b1;
         end else begin
            e1_in = push_res;
            v1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign full      = v1_ff;
   assign rsp_valid = v0_ff;
   assign rsp_res   = e0_ff;

endmodule

// ===== src/ufp_checker.sv =====
module ufp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ufp_pkg::KIND_W-1:0]  rsp_kind,
   input logic [ufp_pkg::BYTE_W-1:0]  rsp_data_byte,
   input logic [ufp_pkg::BYTE_W-1:0]  rsp_payload_index,
   input logic [ufp_pkg::BYTE_W-1:0]  rsp_command,
   input logic [ufp_pkg::BYTE_W-1:0]  rsp_length,
   input logic [ufp_pkg::BYTE_W-1:0]  rsp_sequence_res
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_command))
      else $error("stalled result changed");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_frame_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ufp_pkg::KIND_PAYLOAD
         |-> rsp_data_byte == '0 && rsp_payload_index == '0)
      else $error("payload fields set on a non-payload result");

   a_abort_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != ufp_pkg::KIND_COMPLETE
         |-> rsp_command == '0 && rsp_length == '0 && rsp_sequence_res == '0)
      else $error("frame fields set on a result that is not a completion");

endmodule

bind update_frame_parser ufp_checker u_ufp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_payload_index (rsp_payload_index),
   .rsp_command       (rsp_command),
   .rsp_length        (rsp_length),
   .rsp_sequence_res  (rsp_sequence_res)
);

// ===== tb/update_frame_parser_checker.sv =====
`timescale 1ns / 100ps

module update_frame_parser_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [ufp_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ufp_pkg::KIND_W-1:0]  rsp_kind,
   input  logic [ufp_pkg::BYTE_W-1:0]  rsp_data_byte,
   input  logic [ufp_pkg::BYTE_W-1:0]  rsp_payload_index,
   input  logic [ufp_pkg::BYTE_W-1:0]  rsp_command,
   input  logic [ufp_pkg::BYTE_W-1:0]  rsp_length,
   input  logic [ufp_pkg::BYTE_W-1:0]  rsp_sequence_res,
   input  logic [ufp_pkg::STAT_W-1:0]  rsp_status_code,
   input  logic                        csr_wr_en,
   input  logic [ufp_pkg::IDX_W-1:0]   csr_index,
   input  logic [ufp_pkg::HDR_W-1:0]   csr_wdata,
   output int                          fail_count,
   output int                          pending_count,
   output int                          frames_done,
   output int                          frames_aborted,
   output int                          payload_seen,
   output bit   [7:0]                  status_seen
);
   import ufp_pkg::*;

   cfg_type            cfg;
   logic [POS_W-1:0]   position;
   logic [BYTE_W-1:0]  frame_cmd;
   logic [BYTE_W-1:0]  frame_len;
   logic [BYTE_W-1:0]  frame_seq;
   logic [STAT_W-1:0]  update_status;
   result_type         pending_results[$];

   task automatic report_mismatch(input string msg);
      if (fail_count < 100)
         $display("%t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
   endtask

   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      result_type        r;
      logic              emit;
      logic [POS_W-1:0]  pay_end;
      logic [POS_W-1:0]  idx;
      r = '0;
      emit = 1'b0;
      pay_end = POS_PAY + {1'b0, frame_len};
      if (position == POS_HDR_LO) begin
         // anything but the first header byte is line noise here
         if (b == cfg.header_word[7:0])
            position = POS_HDR_HI;
      end else if (position == POS_HDR_HI) begin
         if (b == cfg.header_word[15:8]) begin
            position = POS_CMD;
         end else begin
            r.kind = KIND_ABORT;
            emit = 1'b1;
            position = POS_HDR_LO;
         end
      end else if (position == POS_CMD) begin
         frame_cmd = b;
         position = POS_LEN;
      end else if (position == POS_LEN) begin
         frame_len = b;
         position = POS_PAY;
      end else if (position < pay_end) begin
         idx = position - POS_PAY;
         r.kind = KIND_PAYLOAD;
         r.data_byte = b;
         r.payload_index = idx[BYTE_W-1:0];
         emit = 1'b1;
         position = position + 1'b1;
      end else if (position == pay_end) begin
         frame_seq = b;
         position = position + 1'b1;
      end else if (position == pay_end + 1'b1 && b == cfg.end_byte) begin
         // first match wins; an unknown command keeps the old status
         if (frame_cmd == cfg.cmd_sync)
            update_status = ST_WAIT;
         else if (frame_cmd == cfg.cmd_ask_update)
            update_status = ST_START;
         else if (frame_cmd == cfg.cmd_update_data)
            update_status = ST_PROG;
         else if (frame_cmd == cfg.cmd_verify)
            update_status = ST_CHECK;
         else if (frame_cmd == cfg.cmd_update_end)
            update_status = ST_END;
         r.kind = KIND_COMPLETE;
         r.command = frame_cmd;
         r.length = frame_len;
         r.sequence_res = frame_seq;
         emit = 1'b1;
         position = POS_HDR_LO;
      end else begin
         r.kind = KIND_ABORT;
         emit = 1'b1;
         position = POS_HDR_LO;
      end
      if (emit) begin
         r.status_code = update_status;
         pending_results.push_back(r);
         pending_count++;
      end
   endtask

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending, kind %0d", rsp_kind));
      end else begin
         want = pending_results.pop_front();
         pending_count--;
         check_field("kind", 16'(rsp_kind), 16'(want.kind));
         check_field("data_byte", 16'(rsp_data_byte), 16'(want.data_byte));
         check_field("payload_index", 16'(rsp_payload_index),
                     16'(want.payload_index));
         check_field("command", 16'(rsp_command), 16'(want.command));
         check_field("length", 16'(rsp_length), 16'(want.length));
         check_field("sequence_res", 16'(rsp_sequence_res),
                     16'(want.sequence_res));
         check_field("status_code", 16'(rsp_status_code), 16'(want.status_code));
      end
      if (rsp_kind == KIND_COMPLETE) begin
         frames_done++;
         status_seen[rsp_status_code] = 1'b1;
      end else if (rsp_kind == KIND_ABORT) begin
         frames_aborted++;
      end else begin
         payload_seen++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '0;
         position = POS_HDR_LO;
         frame_cmd = '0;
         frame_len = '0;
         frame_seq = '0;
         update_status = ST_NONE;
         pending_results.delete();
         pending_count = 0;
         fail_count = 0;
         frames_done = 0;
         frames_aborted = 0;
         payload_seen = 0;
         status_seen = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_HEADER_WORD:     cfg.header_word = csr_wdata;
               REG_END_BYTE:        cfg.end_byte = csr_wdata[BYTE_W-1:0];
               REG_CMD_SYNC:        cfg.cmd_sync = csr_wdata[BYTE_W-1:0];
               REG_CMD_ASK_UPDATE:  cfg.cmd_ask_update = csr_wdata[BYTE_W-1:0];
               REG_CMD_UPDATE_DATA: cfg.cmd_update_data = csr_wdata[BYTE_W-1:0];
               REG_CMD_VERIFY:      cfg.cmd_verify = csr_wdata[BYTE_W-1:0];
               REG_CMD_UPDATE_END:  cfg.cmd_update_end = csr_wdata[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            deframe_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall)
            check_result();
      end
   end

endmodule

// ===== tb/update_frame_parser_tb.sv =====
`timescale 1ns / 100ps

module update_frame_parser_tb;
   import ufp_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASES       = 8;
   localparam int PHASE_BYTES  = 90;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_END, FLAW_CUT} flaw_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [KIND_W-1:0]  rsp_kind;
   logic [BYTE_W-1:0]  rsp_data_byte;
   logic [BYTE_W-1:0]  rsp_payload_index;
   logic [BYTE_W-1:0]  rsp_command;
   logic [BYTE_W-1:0]  rsp_length;
   logic [BYTE_W-1:0]  rsp_sequence_res;
   logic [STAT_W-1:0]  rsp_status_code;
   logic               csr_wr_en = 1'b0;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [HDR_W-1:0]   csr_wdata = '0;

   int       fail_count;
   int       pending_count;
   int       frames_done;
   int       frames_aborted;
   int       payload_seen;
   bit [7:0] status_seen;

   cfg_type  frame_cfg;
   int       req_idle_pct = 20;
   int       rsp_idle_pct = 25;
   int       stall_left = 0;
   int       cycles = 0;
   int       bytes_sent = 0;
   int       phase_bytes = 0;
   int       big_budget = 2;

   always #10 clock = ~clock;

   update_frame_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_command       (rsp_command),
      .rsp_length        (rsp_length),
      .rsp_sequence_res  (rsp_sequence_res),
      .rsp_status_code   (rsp_status_code),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   update_frame_parser_checker frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_command       (rsp_command),
      .rsp_length        (rsp_length),
      .rsp_sequence_res  (rsp_sequence_res),
      .rsp_status_code   (rsp_status_code),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .frames_done       (frames_done),
      .frames_aborted    (frames_aborted),
      .payload_seen      (payload_seen),
      .status_seen       (status_seen)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      if ($urandom_range(1, 100) > req_idle_pct)
         return 0;
      return gap_len();
   endfunction

   function automatic logic [BYTE_W-1:0] pick_command();
      case ($urandom_range(0, 6))
         0: return frame_cfg.cmd_sync;
         1: return frame_cfg.cmd_ask_update;
         2: return frame_cfg.cmd_update_data;
         3: return frame_cfg.cmd_verify;
         4: return frame_cfg.cmd_update_end;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3 && big_budget > 0) begin
         big_budget--;
         return $urandom_range(200, 255);
      end
      if (r < 75)
         return $urandom_range(0, 6);
      return $urandom_range(7, 40);
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.header_word = 16'($urandom_range(0, 65535));
      c.end_byte = 8'($urandom_range(0, 255));
      c.cmd_sync = 8'($urandom_range(0, 255));
      c.cmd_ask_update = 8'($urandom_range(0, 255));
      c.cmd_update_data = 8'($urandom_range(0, 255));
      c.cmd_verify = 8'($urandom_range(0, 255));
      c.cmd_update_end = 8'($urandom_range(0, 255));
      // shared command codes exercise the match priority
      if ($urandom_range(0, 3) == 0)
         c.cmd_verify = c.cmd_ask_update;
      if ($urandom_range(0, 3) == 0)
         c.cmd_update_end = c.cmd_sync;
      return c;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      phase_bytes++;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] command, input int len,
                             input flaw_type flaw);
      logic [BYTE_W-1:0] frame_bytes[$];
      int keep;
      frame_bytes.push_back(frame_cfg.header_word[7:0]);
      if (flaw == FLAW_HEADER) begin
         frame_bytes.push_back(frame_cfg.header_word[15:8] ^ 8'($urandom_range(1, 255)));
      end else begin
         frame_bytes.push_back(frame_cfg.header_word[15:8]);
         frame_bytes.push_back(command);
         frame_bytes.push_back(len[BYTE_W-1:0]);
         for (int i = 0; i < len; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
         frame_bytes.push_back(8'($urandom_range(0, 255)));
         if (flaw == FLAW_END)
            frame_bytes.push_back(frame_cfg.end_byte ^ 8'($urandom_range(1, 255)));
         else
            frame_bytes.push_back(frame_cfg.end_byte);
      end
      // drop the tail so the next frame lands mid-parse
      if (flaw == FLAW_CUT) begin
         keep = $urandom_range(3, frame_bytes.size() - 1);
         while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
      end
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i]);
   endtask

   // hold the sender until every pending result has been taken
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [HDR_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic write_config(input cfg_type c);
      frame_cfg = c;
      write_reg(REG_HEADER_WORD, c.header_word);
      write_reg(REG_END_BYTE, {8'h00, c.end_byte});
      write_reg(REG_CMD_SYNC, {8'h00, c.cmd_sync});
      write_reg(REG_CMD_ASK_UPDATE, {8'h00, c.cmd_ask_update});
      write_reg(REG_CMD_UPDATE_DATA, {8'h00, c.cmd_update_data});
      write_reg(REG_CMD_VERIFY, {8'h00, c.cmd_verify});
      write_reg(REG_CMD_UPDATE_END, {8'h00, c.cmd_update_end});
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if ($urandom_range(1, 100) <= rsp_idle_pct) begin
         rsp_stall = 1'b1;
         stall_left = gap_len() - 1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("update_frame_parser regression: fail");
         $finish;
      end
   end

   initial begin
      cfg_type c;
      flaw_type flaw;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] eb;
      int r;
      bit paused;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      c.header_word = 16'h55AA;
      c.end_byte = 8'h0D;
      c.cmd_sync = 8'h01;
      c.cmd_ask_update = 8'h02;
      c.cmd_update_data = 8'h03;
      c.cmd_verify = 8'h04;
      c.cmd_update_end = 8'h05;
      write_config(c);
      lo = c.header_word[7:0];
      hi = c.header_word[15:8];
      eb = c.end_byte;
      // noise at idle, then a bad second header byte
      send_byte(8'h00);
      send_byte(lo); send_byte(8'h00);
      // good frame with extreme payload bytes
      send_byte(lo); send_byte(hi); send_byte(c.cmd_ask_update); send_byte(8'd2);
      send_byte(8'hFF); send_byte(8'h00); send_byte(8'h7E); send_byte(eb);
      // unknown command, empty payload, wrong end byte
      send_byte(lo); send_byte(hi); send_byte(8'h99); send_byte(8'd0);
      send_byte(8'h11); send_byte(8'h00);
      // unknown command that completes: status must hold
      send_byte(lo); send_byte(hi); send_byte(8'hFF); send_byte(8'd0);
      send_byte(8'h80); send_byte(eb);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: c = '0;
            1: c = '1;
            default: c = random_config();
         endcase
         if (phase == 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (phase == 5) begin
            req_idle_pct = 45;
            rsp_idle_pct = 60;
         end else begin
            req_idle_pct = 20;
            rsp_idle_pct = 25;
         end
         write_config(c);
         if (phase == 4)
            write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
         phase_bytes = 0;
         paused = 1'b0;
         if (phase == 1)
            send_frame(pick_command(), 255, FLAW_NONE);
         while (phase_bytes < PHASE_BYTES) begin
            if (phase == 2 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send_byte(8'($urandom_range(0, 255)));
            end else if (r < 16) begin
               flaw = flaw_type'($urandom_range(1, 3));
               send_frame(pick_command(), pick_length(), flaw);
            end else begin
               send_frame(pick_command(), pick_length(), FLAW_NONE);
            end
         end
         wait_drained();
      end

      $display("sent %0d bytes over %0d register settings: %0d frames done, %0d aborted,",
               bytes_sent, PHASES + 1, frames_done, frames_aborted);
      $display("%0d payload bytes, status codes seen on completion %b",
               payload_seen, status_seen[5:0]);
      if (fail_count == 0 && pending_count == 0)
         $display("update_frame_parser regression: pass");
      else
         $display("update_frame_parser regression: fail");
      $finish;
   end

endmodule
